// ===== sv/nvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared constants, codes and controller/datapath interface types for the
// nearest-value search block.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH) + 1;
  localparam int DATA_W      = 32;
  localparam int DIST_W      = DATA_W + 1;
  localparam int COUNT_W     = 11;
  localparam int LIDX_W      = 10;
  localparam int OUT_W       = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // register index (byte address / 4)
  localparam logic [PADDR_W-3:0] REG_ELEMENT_COUNT = '0;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // table read address select
  localparam logic [1:0] RD_I   = 2'd0;
  localparam logic [1:0] RD_MID = 2'd1;
  localparam logic [1:0] RD_LO  = 2'd2;
  localparam logic [1:0] RD_HI  = 2'd3;

  // result select
  localparam logic [1:0] RES_MID = 2'd0;
  localparam logic [1:0] RES_LO  = 2'd1;
  localparam logic [1:0] RES_HI  = 2'd2;

  typedef struct packed {
    logic       wr;
    logic       cap;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       i_dbl;
    logic       setup;
    logic       lo_mid;
    logic       hi_mid;
    logic       dlo_cap;
    logic       dhi_cap;
    logic       res_en;
    logic [1:0] res_sel;
    logic       push;
  } nvs_cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic probe_le;
    logic hi_gt_lo1;
    logic hi_le_lo;
    logic mid_eq;
    logic mid_lt;
    logic dlo_le_dhi;
    logic out_free;
  } nvs_sts_t;

endpackage

// ===== sv/nvs_regs.sv =====
// ----------------------------------------------------------------------------
// nvs_regs
// APB-style register file holding the element count.
// ----------------------------------------------------------------------------
module nvs_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nvs_pkg::PADDR_W-1:0]  paddr,
  input  logic [nvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [nvs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [nvs_pkg::COUNT_W-1:0]  count
);
  import nvs_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               sel_count;

  assign sel_count = (paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT);
  assign pready    = 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (psel && penable && pwrite && pready && sel_count) begin
      count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign prdata = sel_count ? PDATA_W'(count_r) : '0;
  assign count  = count_r;

endmodule

// ===== sv/nvs_datapath.sv =====
// ----------------------------------------------------------------------------
// nvs_datapath
// Table memory, probe/bracket registers, distance compare and output register.
// ----------------------------------------------------------------------------
module nvs_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nvs_pkg::nvs_cmd_t            cmd,
  output nvs_pkg::nvs_sts_t            sts,
  input  logic [nvs_pkg::COUNT_W-1:0]  count,
  input  logic [nvs_pkg::LIDX_W-1:0]   in_load_index,
  input  logic signed [nvs_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nvs_pkg::OUT_W-1:0]    out_nearest_index
);
  import nvs_pkg::*;

  logic signed [DATA_W-1:0] tbl_r [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] x_r;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         i_r, i_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [DIST_W-1:0]        dlo_r;
  logic [DIST_W-1:0]        dhi_r;
  logic [IDX_W-1:0]         res_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_idx_r;

  logic [CNT_W:0]           sum_lh;
  logic [CNT_W-1:0]         mid;
  logic [CNT_W-1:0]         n_m1;
  logic [CNT_W-1:0]         hi_init;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [DIST_W-1:0] diff;
  logic [DIST_W-1:0]        abs_diff;
  logic [IDX_W-1:0]         res_nxt;
  logic                     wr_ok;

  assign sum_lh  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = sum_lh[CNT_W:1];
  assign n_m1    = n_r - CNT_W'(1);
  assign hi_init = (i_r < n_m1) ? i_r : n_m1;

  // clamp the count into 1..TABLE_DEPTH
  always_comb begin
    if (count == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(count) > TABLE_DEPTH) begin
      n_nxt = CNT_W'(TABLE_DEPTH);
    end else begin
      n_nxt = CNT_W'(count);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    rd_addr = i_r[IDX_W-1:0];
      RD_MID:  rd_addr = mid[IDX_W-1:0];
      RD_LO:   rd_addr = lo_r[IDX_W-1:0];
      RD_HI:   rd_addr = hi_r[IDX_W-1:0];
      default: rd_addr = i_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      RES_MID: res_nxt = mid[IDX_W-1:0];
      RES_LO:  res_nxt = lo_r[IDX_W-1:0];
      RES_HI:  res_nxt = hi_r[IDX_W-1:0];
      default: res_nxt = lo_r[IDX_W-1:0];
    endcase
  end

  assign diff     = {rdata_r[DATA_W-1], rdata_r} - {x_r[DATA_W-1], x_r};
  assign abs_diff = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

  assign wr_ok = (32'(in_load_index) < TABLE_DEPTH);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      tbl_r[IDX_W'(in_load_index)] <= in_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= tbl_r[rd_addr];
    end
  end

  always_comb begin
    i_nxt  = i_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.cap) begin
      i_nxt = CNT_W'(1);
    end else if (cmd.i_dbl) begin
      i_nxt = i_r << 1;
    end
    if (cmd.setup) begin
      lo_nxt = i_r >> 1;
      hi_nxt = hi_init;
    end else if (cmd.lo_mid) begin
      lo_nxt = mid;
    end else if (cmd.hi_mid) begin
      hi_nxt = mid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x_r <= in_value;
      n_r <= n_nxt;
    end
    i_r  <= i_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.dlo_cap) begin
      dlo_r <= abs_diff;
    end
    if (cmd.dhi_cap) begin
      dhi_r <= abs_diff;
    end
    if (cmd.res_en) begin
      res_r <= res_nxt;
    end
    if (cmd.push) begin
      out_idx_r <= OUT_W'(res_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.i_lt_n     = (i_r < n_r);
  assign sts.probe_le   = (rdata_r <= x_r);
  assign sts.hi_gt_lo1  = ({1'b0, hi_r} > ({1'b0, lo_r} + (CNT_W+1)'(1)));
  assign sts.hi_le_lo   = (hi_r <= lo_r);
  assign sts.mid_eq     = (rdata_r == x_r);
  assign sts.mid_lt     = (rdata_r < x_r);
  assign sts.dlo_le_dhi = (dlo_r <= dhi_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

endmodule

// ===== sv/nvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvs_ctrl
// Search sequencer: doubling probe, bisection, final distance pick.
// ----------------------------------------------------------------------------
module nvs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  nvs_pkg::nvs_sts_t sts,
  output nvs_pkg::nvs_cmd_t cmd
);
  import nvs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PCHK = 4'd1;
  localparam logic [3:0] S_PCMP = 4'd2;
  localparam logic [3:0] S_BCHK = 4'd3;
  localparam logic [3:0] S_BCMP = 4'd4;
  localparam logic [3:0] S_FLO  = 4'd5;
  localparam logic [3:0] S_FHI  = 4'd6;
  localparam logic [3:0] S_FCMP = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_operation == OP_LOAD) begin
          cmd.wr = 1'b1;
        end else if (accept && in_operation == OP_QUERY) begin
          cmd.cap   = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts.i_lt_n) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I;
          state_nxt  = S_PCMP;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = S_BCHK;
        end
      end
      S_PCMP: begin
        if (sts.probe_le) begin
          cmd.i_dbl = 1'b1;
          state_nxt = S_PCHK;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts.hi_gt_lo1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_nxt  = S_BCMP;
        end else if (sts.hi_le_lo) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_LO;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LO;
          state_nxt  = S_FLO;
        end
      end
      S_BCMP: begin
        if (sts.mid_eq) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = RES_MID;
          state_nxt   = S_DONE;
        end else if (sts.mid_lt) begin
          cmd.lo_mid = 1'b1;
          state_nxt  = S_BCHK;
        end else begin
          cmd.hi_mid = 1'b1;
          state_nxt  = S_BCHK;
        end
      end
      S_FLO: begin
        cmd.dlo_cap = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_HI;
        state_nxt   = S_FHI;
      end
      S_FHI: begin
        cmd.dhi_cap = 1'b1;
        state_nxt   = S_FCMP;
      end
      S_FCMP: begin
        // tie goes to the lower index
        cmd.res_en  = 1'b1;
        cmd.res_sel = sts.dlo_le_dhi ? RES_LO : RES_HI;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_query_starts_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_QUERY) |=> (state_r == S_PCHK))
    else $error("query accept did not start the probe phase");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("result pushed into a full output register");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");

  a_mid_read_compared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_MID) |=> (state_r == S_BCMP))
    else $error("bisection read not followed by compare");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (state_r == S_IDLE && !cmd.rd_en))
    else $error("table write outside idle");
`endif

endmodule

// ===== sv/nearest_value_search.sv =====
// ----------------------------------------------------------------------------
// nearest_value_search
// Sorted-table nearest-value lookup by doubling probe and bisection.
// ----------------------------------------------------------------------------
// Load beat: written at its accept edge; the next beat can follow at once.
// Query beat: P <= log2(depth) probe reads and B < log2(depth) bisection reads between
//   accept and out_valid, then at most one distance pick between two neighbouring entries.
// One query in flight; a finished result waits until the output register is free, and the
//   next beat is accepted the cycle after the result is pushed.
// Synchronous active-low reset clears control, sets element_count to 1; table undefined.
module nearest_value_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [nvs_pkg::LIDX_W-1:0]        in_load_index,
  input  logic signed [nvs_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nvs_pkg::OUT_W-1:0]         out_nearest_index,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nvs_pkg::PADDR_W-1:0]       paddr,
  input  logic [nvs_pkg::PDATA_W-1:0]       pwdata,
  output logic [nvs_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import nvs_pkg::*;

  nvs_cmd_t           cmd;
  nvs_sts_t           sts;
  logic [COUNT_W-1:0] count;

  nvs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count   (count)
  );

  nvs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  nvs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .count             (count),
    .in_load_index     (in_load_index),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index)
  );

endmodule

// ===== tb/sv/nearest_value_search_checker.sv =====
// ----------------------------------------------------------------------------
// nearest_value_search_checker
// Watches the item, result and register ports of the nearest-value search,
// keeps its own copy of the table and element count, predicts the index each
// query must return, and compares every result beat against it in order.
// ----------------------------------------------------------------------------
module nearest_value_search_checker
  import nvs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_operation,
  input  logic [LIDX_W-1:0]        in_load_index,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [OUT_W-1:0]         out_nearest_index,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  input  logic [PDATA_W-1:0]       prdata,
  input  logic                     pready,
  output int                       mismatch_count,
  output int                       pending_results,
  output int                       results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [OUT_W-1:0]         index;
    logic signed [DATA_W-1:0] query;
  } answer_t;

  logic signed [DATA_W-1:0] table_copy [TABLE_DEPTH];
  logic [COUNT_W-1:0]       elem_count;
  answer_t                  expected_answers [$];
  int                       errors;
  int                       checked;

  initial begin
    elem_count      = COUNT_RESET;
    errors          = 0;
    checked         = 0;
    mismatch_count  = 0;
    pending_results = 0;
    results_checked = 0;
  end

  // Doubling probe to bracket the query, then bisection; ties go low.
  function automatic logic [OUT_W-1:0] nearest_index_of(input logic signed [DATA_W-1:0] x);
    int     n;
    int     probe;
    int     lo;
    int     hi;
    int     mid;
    longint d_lo;
    longint d_hi;
    n = int'(elem_count);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    probe = 1;
    while (probe < n && table_copy[probe] <= x) probe = probe * 2;
    lo = probe / 2;
    hi = (probe < n - 1) ? probe : n - 1;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2;
      if (table_copy[mid] == x) return OUT_W'(mid);
      if (table_copy[mid] < x) lo = mid;
      else hi = mid;
    end
    if (hi <= lo) return OUT_W'(lo);
    d_lo = longint'(table_copy[lo]) - longint'(x);
    d_hi = longint'(table_copy[hi]) - longint'(x);
    if (d_lo < 0) d_lo = -d_lo;
    if (d_hi < 0) d_hi = -d_hi;
    return (d_lo <= d_hi) ? OUT_W'(lo) : OUT_W'(hi);
  endfunction

  always @(posedge clk) begin
    answer_t due;
    if (!rst_n) begin
      elem_count = COUNT_RESET;
      expected_answers.delete();
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT) begin
        if (pwrite) begin
          elem_count = pwdata[COUNT_W-1:0];
        end else if (prdata[COUNT_W-1:0] !== elem_count) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t element_count readback: expected %0d got %0d",
                     $realtime, elem_count, prdata[COUNT_W-1:0]);
        end
      end
      // Retire the result beat before taking a new query.
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t result beat with no query waiting: got index %0d",
                     $realtime, out_nearest_index);
        end else begin
          due = expected_answers.pop_front();
          checked++;
          if (out_nearest_index !== due.index) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t nearest_index for query %0d: expected %0d got %0d",
                       $realtime, due.query, due.index, out_nearest_index);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_operation == OP_LOAD) begin
          if (in_load_index < TABLE_DEPTH) table_copy[in_load_index] = in_value;
        end else begin
          due.index = nearest_index_of(in_value);
          due.query = in_value;
          expected_answers.push_back(due);
        end
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_answers.size();
    results_checked <= checked;
  end

endmodule

// ===== tb/sv/nearest_value_search_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_value_search_tb
// Drives loads, queries and element_count writes into the nearest-value search
// with random gaps and output stalls, including one long output hold-off, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module nearest_value_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nvs_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_WAIT       = 18;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 48;
  localparam int ITEM_TARGET    = 1200;
  localparam int COUNT_MAX      = 2**COUNT_W - 1;

  localparam logic [PADDR_W-1:0]       COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
  localparam logic signed [DATA_W-1:0] VALUE_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX  = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_operation = OP_LOAD;
  logic [LIDX_W-1:0]        in_load_index = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [OUT_W-1:0]         out_nearest_index;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     hold_go = 1'b0;

  int mismatch_count;
  int pending_results;
  int results_checked;

  logic signed [DATA_W-1:0] entry_vals [TABLE_DEPTH];
  longint                   ladder [TABLE_DEPTH];
  bit                       send_quiet = 1'b0;
  int                       n_loads = 0;
  int                       n_queries = 0;
  int                       n_settings = 0;
  int                       max_eff = 0;
  int                       idle_cycles = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  nearest_value_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_load_index     (in_load_index),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  nearest_value_search_checker answer_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_load_index     (in_load_index),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  // Result side: random stall per beat, quiet stretches, one long hold-off.
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_count;
    bit          sink_quiet;
    wait_left  = 0;
    hold_count = 0;
    sink_quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
        wait_left = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid && wait_left > 0) begin
        wait_left--;
      end
      if (hold_go && hold_count < HOLD_CYCLES) begin
        hold_count++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (wait_left > 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one beat after a random gap; return at the edge that accepts it.
  task automatic send_beat(input logic op, input logic [LIDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_load_index <= idx;
    in_value      <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) n_loads++;
    else n_queries++;
  endtask

  // Drop valid, wait out every pending result, then let loads settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write element_count, then read it back for the checker.
  task automatic reprogram_count(input int cnt);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= PDATA_W'(cnt);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Fill entries 0..eff-1, ascending and distinct unless scrambled.
  task automatic load_entries(input int eff, input bit sorted);
    longint step_max;
    longint total;
    longint start;
    if (eff > max_eff) max_eff = eff;
    if (sorted) begin
      case ($urandom_range(0, 2))
        0:       step_max = 3;
        1:       step_max = 1000;
        default: step_max = 64'hFFFF_FFFF / eff;
      endcase
      ladder[0] = 0;
      for (int k = 1; k < eff; k++)
        ladder[k] = ladder[k-1] + $urandom_range(1, int'(step_max));
      total = ladder[eff-1];
      case ($urandom_range(0, 3))
        0:       start = longint'(VALUE_MIN);
        1:       start = longint'(VALUE_MAX) - total;
        default: start = longint'(VALUE_MIN) + $urandom_range(0, int'(64'hFFFF_FFFF - total));
      endcase
      for (int k = 0; k < eff; k++) entry_vals[k] = DATA_W'(start + ladder[k]);
    end else begin
      for (int k = 0; k < eff; k++) entry_vals[k] = $urandom;
    end
    for (int k = 0; k < eff; k++) send_beat(OP_LOAD, LIDX_W'(k), entry_vals[k]);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_query(input int eff);
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, eff - 1);
    if (pick < 30) return entry_vals[k];
    if (pick < 45) return entry_vals[k] + ($urandom_range(0, 1) ? 1 : -1);
    if (pick < 55 && k + 1 < eff)
      return DATA_W'((longint'(entry_vals[k]) + longint'(entry_vals[k+1])) >>> 1);
    if (pick < 65) begin
      case ($urandom_range(0, 3))
        0:       return VALUE_MIN;
        1:       return VALUE_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly queries; now and then a stray load that may break the ordering.
  task automatic query_burst(input int eff, input int beats);
    int unsigned idx;
    logic signed [DATA_W-1:0] val;
    repeat (beats) begin
      if ($urandom_range(0, 11) == 0) begin
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        val = $urandom;
        entry_vals[idx] = val;
        send_beat(OP_LOAD, LIDX_W'(idx), val);
      end else begin
        send_beat(OP_QUERY, LIDX_W'($urandom), pick_query(eff));
      end
    end
  endtask

  function automatic int choose_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $urandom_range(1, 16);
    if (pick < 80) return $urandom_range(17, 128);
    if (pick < 88) return $urandom_range(129, TABLE_DEPTH - 1);
    if (pick < 93) return TABLE_DEPTH;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return COUNT_MAX;
      default: return $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
    endcase
  endfunction

  task automatic run_phase(input int cnt, input bit hold_output);
    int eff;
    reprogram_count(cnt);
    eff = (cnt == 0) ? 1 : (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    send_quiet = ($urandom_range(0, 3) == 0);
    // Large tables reuse the full load done up front.
    if (eff <= 128)
      load_entries(eff, $urandom_range(0, 6) != 0);
    if (eff > max_eff) max_eff = eff;
    if (hold_output) hold_go <= 1'b1;
    query_burst(eff, $urandom_range(8, 40));
  endtask

  initial begin : stimulus
    int phase_no;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single entry after reset, top load index, value extremes.
    send_beat(OP_LOAD, LIDX_W'(TABLE_DEPTH - 1), '1);
    send_beat(OP_QUERY, '0, VALUE_MIN);
    send_beat(OP_QUERY, '1, VALUE_MAX);
    // A count of zero behaves as one entry.
    reprogram_count(0);
    send_beat(OP_QUERY, '0, 12345);
    // Full-range entries: distances need the extra bit.
    reprogram_count(2);
    send_beat(OP_LOAD, LIDX_W'(0), VALUE_MIN);
    send_beat(OP_LOAD, LIDX_W'(1), VALUE_MAX);
    send_beat(OP_QUERY, '0, VALUE_MIN);
    send_beat(OP_QUERY, '0, VALUE_MAX);
    send_beat(OP_QUERY, '0, '1);
    send_beat(OP_QUERY, '0, '0);
    // Equal distances resolve to the lower index; exact hit; outside the range.
    reprogram_count(3);
    send_beat(OP_LOAD, LIDX_W'(0), -10);
    send_beat(OP_LOAD, LIDX_W'(1), 10);
    send_beat(OP_LOAD, LIDX_W'(2), 30);
    send_beat(OP_QUERY, '0, 0);
    send_beat(OP_QUERY, '0, 20);
    send_beat(OP_QUERY, '0, 10);
    send_beat(OP_QUERY, '0, -100);
    send_beat(OP_QUERY, '0, 100);
    // Unsorted table: same steps, answer need not be nearest.
    send_beat(OP_LOAD, LIDX_W'(1), -50);
    send_beat(OP_QUERY, '0, -20);

    // Load the whole table once so that any count reads only written entries.
    reprogram_count(TABLE_DEPTH);
    send_quiet = 1'b0;
    load_entries(TABLE_DEPTH, 1'b1);
    query_burst(TABLE_DEPTH, 40);
    // Count above the depth saturates.
    reprogram_count(COUNT_MAX);
    query_burst(TABLE_DEPTH, 30);

    phase_no = 0;
    while (n_loads + n_queries < ITEM_TARGET) begin
      phase_no++;
      run_phase(choose_count(), phase_no == 1);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d input beats (%0d loads, %0d queries) over %0d count settings,",
             n_loads + n_queries, n_loads, n_queries, n_settings);
    $display("  %0d search results compared, tables up to %0d entries",
             results_checked, max_eff);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
